FILE: sv/csr_pkg.sv
`default_nettype none

package csr_pkg;

    localparam int COORD_W = 12;
    localparam int RAD_W   = 6;
    localparam int COLOR_W = 32;
    localparam int MODE_W  = 2;
    localparam int SCR_W   = 12;
    localparam int ROW_W   = 11;
    localparam int LEN_W   = 12;
    localparam int ARG_W   = 13;
    localparam int ROOT_W  = 7;
    localparam int WORK_W  = 14;

    localparam logic [SCR_W-1:0] SCREEN_LIMIT   = 12'd2048;
    localparam logic [SCR_W-1:0] WIDTH_RESET    = 12'd960;
    localparam logic [SCR_W-1:0] HEIGHT_RESET   = 12'd540;
    localparam logic             REG_WIDTH      = 1'b0;
    localparam logic             REG_HEIGHT     = 1'b1;
    localparam logic [ARG_W-1:0] ROOT_FIRST_BIT = 13'h1000;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RAD_W-1:0]          r;
        logic [COLOR_W-1:0]        color;
        logic [MODE_W-1:0]         mode;
    } csr_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ARG,
        S_ROOT,
        S_CLIP
    } csr_state_t;

endpackage

`default_nettype wire

FILE: sv/csr_front.sv
`default_nettype none

module csr_front
    import csr_pkg::*;
#(
    parameter int MAX_RADIUS = 32
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic signed [COORD_W-1:0]  center_x,
    input  wire logic signed [COORD_W-1:0]  center_y,
    input  wire logic [RAD_W-1:0]           radius,
    input  wire logic [COLOR_W-1:0]         fill_color,
    input  wire logic [MODE_W-1:0]          blend_mode,
    output logic                            cmd_valid,
    input  wire logic                       cmd_take,
    output csr_cmd_t                        cmd
);

    csr_cmd_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       accept;
    logic       keep;
    logic       take;
    csr_cmd_t   incoming;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign accept    = push && !full;

    // A circle of zero radius has no rows, so it is dropped here.
    assign keep      = accept && (radius != '0);
    assign take      = cmd_take && cmd_valid;

    always_comb
    begin
        incoming.cx    = center_x;
        incoming.cy    = center_y;
        incoming.r     = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;
        incoming.color = fill_color;
        incoming.mode  = blend_mode;
    end

    always_comb
    begin
        wr_ptr_next = keep ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, keep} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

FILE: sv/csr_isqrt.sv
`default_nettype none

module csr_isqrt
    import csr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ARG_W-1:0]  arg,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    logic [ARG_W-1:0]  rem_reg;
    logic [ARG_W-1:0]  rem_next;
    logic [WORK_W-1:0] root_reg;
    logic [WORK_W-1:0] root_next;
    logic [ARG_W-1:0]  bit_reg;
    logic [ARG_W-1:0]  bit_next;
    logic              active_reg;
    logic              active_next;
    logic              done_reg;
    logic              done_next;
    logic [WORK_W-1:0] trial;

    assign done = done_reg;
    assign root = root_reg[ROOT_W-1:0];
    assign trial = root_reg + {1'b0, bit_reg};

    // One result bit is settled per cycle, starting from the top bit pair.
    always_comb
    begin
        rem_next    = rem_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (start)
        begin
            rem_next    = arg;
            root_next   = '0;
            bit_next    = ROOT_FIRST_BIT;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next  = rem_reg - trial[ARG_W-1:0];
                root_next = (root_reg >> 1) + {1'b0, bit_reg};
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

endmodule

`default_nettype wire

FILE: sv/csr_back.sv
`default_nettype none

module csr_back
    import csr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SCR_W-1:0]  scr_width,
    input  wire logic [SCR_W-1:0]  scr_height,
    input  wire logic              cmd_valid,
    output logic                   cmd_take,
    input  wire csr_cmd_t          cmd,
    output logic                   empty,
    input  wire logic              pop,
    output logic [ROW_W-1:0]       span_row,
    output logic [ROW_W-1:0]       span_start,
    output logic [LEN_W-1:0]       span_length,
    output logic                   visible,
    output logic [COLOR_W-1:0]     span_color,
    output logic [MODE_W-1:0]      span_mode,
    output logic                   last
);

    csr_state_t         state_reg;
    csr_state_t         state_next;
    csr_cmd_t           cur_reg;
    csr_cmd_t           cur_next;
    logic [RAD_W-1:0]   idx_reg;
    logic [RAD_W-1:0]   idx_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [ROW_W-1:0]   start_reg;
    logic [ROW_W-1:0]   start_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic               vis_reg;
    logic               vis_next;
    logic               last_reg;
    logic               last_next;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;
    logic [MODE_W-1:0]  mode_reg;
    logic [MODE_W-1:0]  mode_next;

    logic               sq_start;
    logic               sq_done;
    logic [ROOT_W-1:0]  sq_root;
    logic [ARG_W-1:0]   sq_arg;

    logic               out_free;
    logic               row_last;
    logic signed [RAD_W:0]    d;
    logic signed [WORK_W-1:0] d_sq;
    logic [ARG_W-2:0]         r_sq;
    logic [ARG_W-2:0]         diff;
    logic signed [WORK_W-1:0] row_s;
    logic signed [WORK_W-1:0] xofs0;
    logic signed [WORK_W-1:0] xofs_a;
    logic signed [WORK_W-1:0] len_a;
    logic signed [WORK_W-1:0] len_b;
    logic signed [WORK_W-1:0] w_s;
    logic                     row_ok;
    logic                     vis_c;

    csr_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .arg   (sq_arg),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign empty       = !out_valid_reg;
    assign span_row    = row_reg;
    assign span_start  = start_reg;
    assign span_length = len_reg;
    assign visible     = vis_reg;
    assign span_color  = color_reg;
    assign span_mode   = mode_reg;
    assign last        = last_reg;

    assign out_free = !out_valid_reg || pop;
    assign row_last = ({1'b0, idx_reg} == ({cur_reg.r, 1'b0} - 7'd1));

    // Chord argument: 4 * (r*r - (r - i)^2), always below 2^13.
    always_comb
    begin
        d      = $signed({1'b0, cur_reg.r}) - $signed({1'b0, idx_reg});
        d_sq   = WORK_W'(d * d);
        r_sq   = (ARG_W-1)'(cur_reg.r * cur_reg.r);
        diff   = r_sq - d_sq[ARG_W-2:0];
        sq_arg = {diff[ARG_W-3:0], 2'b00};
    end

    always_comb
    begin
        w_s    = $signed({2'b00, scr_width});
        row_s  = WORK_W'(cur_reg.cy) - $signed({8'd0, cur_reg.r})
                 + $signed({8'd0, idx_reg});
        row_ok = !row_s[WORK_W-1]
                 && (row_s[WORK_W-2:0] < {1'b0, scr_height});
        xofs0  = WORK_W'(cur_reg.cx) - $signed({8'd0, sq_root[ROOT_W-1:1]});
        if (xofs0[WORK_W-1])
        begin
            len_a  = $signed({7'd0, sq_root}) + xofs0;
            xofs_a = '0;
        end
        else
        begin
            len_a  = $signed({7'd0, sq_root});
            xofs_a = xofs0;
        end
        if ((xofs_a + len_a) >= w_s)
        begin
            len_b = w_s - xofs_a;
        end
        else
        begin
            len_b = len_a;
        end
        vis_c = row_ok && !len_b[WORK_W-1] && (len_b != '0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_ARG;
                end
            end
            S_ARG:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (sq_done)
                begin
                    state_next = S_CLIP;
                end
            end
            S_CLIP:
            begin
                if (out_free)
                begin
                    state_next = row_last ? S_IDLE : S_ARG;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_take       = 1'b0;
        sq_start       = 1'b0;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !pop;
        row_next       = row_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        vis_next       = vis_reg;
        last_next      = last_reg;
        color_next     = color_reg;
        mode_next      = mode_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    cur_next = cmd;
                    idx_next = '0;
                end
            end
            S_ARG:
            begin
                sq_start = 1'b1;
            end
            S_ROOT:
            begin
                sq_start = 1'b0;
            end
            S_CLIP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    vis_next       = vis_c;
                    row_next       = vis_c ? row_s[ROW_W-1:0] : '0;
                    start_next     = vis_c ? xofs_a[ROW_W-1:0] : '0;
                    len_next       = vis_c ? len_b[LEN_W-1:0] : '0;
                    last_next      = row_last;
                    color_next     = cur_reg.color;
                    mode_next      = cur_reg.mode;
                    idx_next       = idx_reg + RAD_W'(1);
                end
            end
            default:
            begin
                cmd_take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        idx_reg   <= idx_next;
        row_reg   <= row_next;
        start_reg <= start_next;
        len_reg   <= len_next;
        vis_reg   <= vis_next;
        last_reg  <= last_next;
        color_reg <= color_next;
        mode_reg  <= mode_next;
    end

endmodule

`default_nettype wire

FILE: sv/circle_span_rasterizer.sv
`default_nettype none

// Channel        Direction  Handshake            Payload
// command        in         push / full          center_x center_y radius fill_color blend_mode
// span           out        empty / pop          span_row span_start span_length visible
//                                                span_color span_mode last
// configuration  in         cfg_we               cfg_addr cfg_wdata
//
// Each row of a circle runs through these steps: the chord argument is formed and
// the root unit started, the root unit takes seven square root steps, the root
// is seen to finish, and the row is clipped and loaded into the span register
// once it is free. A command of radius r gives 2*r rows after it is picked up.
// A two-entry command queue lets new commands arrive while spans are produced.
// The row sequencer halts while the span register is full and not popped.
// Reset clears both queues and loads the screen size of 960 by 540.

module circle_span_rasterizer
    import csr_pkg::*;
#(
    parameter int MAX_RADIUS = 32
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_addr,
    input  wire logic [SCR_W-1:0]           cfg_wdata,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic signed [COORD_W-1:0]  center_x,
    input  wire logic signed [COORD_W-1:0]  center_y,
    input  wire logic [RAD_W-1:0]           radius,
    input  wire logic [COLOR_W-1:0]         fill_color,
    input  wire logic [MODE_W-1:0]          blend_mode,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [ROW_W-1:0]                span_row,
    output logic [ROW_W-1:0]                span_start,
    output logic [LEN_W-1:0]                span_length,
    output logic                            visible,
    output logic [COLOR_W-1:0]              span_color,
    output logic [MODE_W-1:0]               span_mode,
    output logic                            last
);

    logic [SCR_W-1:0] width_reg;
    logic [SCR_W-1:0] width_next;
    logic [SCR_W-1:0] height_reg;
    logic [SCR_W-1:0] height_next;
    logic [SCR_W-1:0] cfg_clamped;
    logic             cmd_valid;
    logic             cmd_take;
    csr_cmd_t         cmd;

    assign cfg_clamped = (cfg_wdata > SCREEN_LIMIT) ? SCREEN_LIMIT : cfg_wdata;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_WIDTH:  width_next  = cfg_clamped;
                REG_HEIGHT: height_next = cfg_clamped;
                default:    width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    csr_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .fill_color (fill_color),
        .blend_mode (blend_mode),
        .cmd_valid  (cmd_valid),
        .cmd_take   (cmd_take),
        .cmd        (cmd)
    );

    csr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .scr_width   (width_reg),
        .scr_height  (height_reg),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .cmd         (cmd),
        .empty       (empty),
        .pop         (pop),
        .span_row    (span_row),
        .span_start  (span_start),
        .span_length (span_length),
        .visible     (visible),
        .span_color  (span_color),
        .span_mode   (span_mode),
        .last        (last)
    );

endmodule

`default_nettype wire
